// ----- rtl/core/slbsm_pkg.sv -----
// Package for the serial-loaded bank switch mapper: request and response
// payload types, command and register codes, and bank table helpers.
// No dependencies.
`timescale 1ns / 1ps

package slbsm_pkg;

  localparam int unsigned PRG_BANKS_MAX_DEF = 16;
  localparam int unsigned CHR_BANKS_MAX_DEF = 16;

  // Reset values of the configuration registers.
  localparam logic [4:0] PRG_BANK_COUNT_RST = 5'd16;
  localparam logic [4:0] CHR_BANK_COUNT_RST = 5'd0;

  // Reset value of the control register and the bits forced by a reset write.
  localparam logic [4:0] CTRL_RST       = 5'h0C;
  localparam logic [4:0] CTRL_FORCE_SET = 5'h0C;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_XLT_PRG = 2'd2,
    CMD_XLT_CHR = 2'd3
  } cmd_t;

  // Mapper register numbers, taken from address bits 14:13.
  localparam logic [1:0] REG_CTRL = 2'd0;
  localparam logic [1:0] REG_CHR0 = 2'd1;
  localparam logic [1:0] REG_CHR1 = 2'd2;
  localparam logic [1:0] REG_PRG  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_PRG_BANKS = 1'b0;
  localparam logic CFG_CHR_BANKS = 1'b1;

  localparam logic [2:0] SHIFT_LAST = 3'd4;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } req_t;

  typedef struct packed {
    logic [4:0]  read_value;
    logic [17:0] phys_offset;
    logic [1:0]  mirroring;
  } rsp_t;

  // Table of v mod m for every four-bit v, built at elaboration by repeated
  // subtraction. Only ever called with a constant bank limit.
  function automatic logic [15:0][3:0] mod_lut(input int unsigned m);
    logic [15:0][3:0] t;
    int unsigned      v;
    for (int i = 0; i < 16; i++) begin
      v = i;
      for (int j = 0; j < 16; j++) begin
        if (v >= m) begin
          v = v - m;
        end
      end
      t[i] = 4'(v);
    end
    return t;
  endfunction

endpackage

// ----- rtl/core/serial_loaded_bank_switch_mapper.sv -----
// Serial-loaded bank switch mapper: register file, shift loader, window
// tables and address translation with a registered response.
// Depends on slbsm_pkg.
`timescale 1ns / 1ps

// How to use this block:
// Requests enter on in_valid/in_ready/in_data: a register write, a register
// read, or a program or character address to translate. Every request gives
// exactly one response on out_valid/out_ready/out_data, carrying the read
// value, the physical byte offset and the current mirroring mode.
// A request accepted at one edge has its response valid right after that
// edge. Throughput is one request per cycle while the receiver does not
// stall; the decode and translate logic sits between the request handshake
// and the single response register, and mapper state updates at the
// accepting edge, so the next request already sees it.
// When the receiver stalls, the response register holds its value and
// in_ready drops only while that register is full and out_ready is low.
// Configuration (program and character bank counts) is written through
// cfg_we/cfg_index/cfg_wdata with no handshake, while the block is idle.
// Synchronous reset clears the shift loader, loads control with 0x0C, maps
// the last program bank at 0xC000, sets character windows to identity
// and restores the bank counts to 16 and 0. No clearing pass is needed.
module serial_loaded_bank_switch_mapper
  import slbsm_pkg::*;
#(
  parameter int unsigned PRG_BANKS_MAX = PRG_BANKS_MAX_DEF,
  parameter int unsigned CHR_BANKS_MAX = CHR_BANKS_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rsp_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam logic [15:0][3:0] PRG_MOD = mod_lut(PRG_BANKS_MAX);
  localparam logic [15:0][3:0] CHR_MOD = mod_lut(CHR_BANKS_MAX);
  localparam logic [4:0] PRG_MAX5 = 5'(PRG_BANKS_MAX);
  localparam logic [3:0] LAST_BANK_RST =
    (PRG_BANK_COUNT_RST > PRG_MAX5) ? 4'(PRG_MAX5 - 5'd1) : 4'(PRG_BANK_COUNT_RST - 5'd1);

  logic [4:0] prg_bank_count;
  logic [4:0] chr_bank_count;

  logic [4:0]       shift_bits, shift_bits_next;
  logic [2:0]       shift_count, shift_count_next;
  logic [1:0]       last_region, last_region_next;
  logic [3:0][4:0]  bank_regs, bank_regs_next;
  logic [3:0][3:0]  prg_window_bank, prg_window_bank_next;
  logic [7:0][16:0] chr_window_offset, chr_window_offset_next;

  logic       accept;
  logic       bus_write;
  logic [1:0] win;
  logic [4:0] n_banks;
  logic [3:0] last_bank;
  logic [4:0] sb;
  logic [2:0] sc;
  logic [4:0] load_value;
  logic       load;
  logic [4:0] ctl;
  logic [3:0] b8;
  logic [3:0] prg_lo;
  logic [2:0] kk;
  rsp_t       rsp;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign win       = in_data.addr[14:13];
  assign bus_write = accept && (in_data.cmd == CMD_WRITE) && in_data.addr[15];

  // Last program bank: a count of zero acts as one, and counts above the
  // supported maximum are clamped.
  always_comb begin
    n_banks = prg_bank_count;
    if (n_banks == 5'd0) begin
      n_banks = 5'd1;
    end
    if (n_banks > PRG_MAX5) begin
      n_banks = PRG_MAX5;
    end
    last_bank = 4'(n_banks - 5'd1);
  end

  always_comb begin
    shift_bits_next        = shift_bits;
    shift_count_next       = shift_count;
    last_region_next       = last_region;
    bank_regs_next         = bank_regs;
    prg_window_bank_next   = prg_window_bank;
    chr_window_offset_next = chr_window_offset;

    // A change of target register abandons a partial serial load.
    sb = (win != last_region) ? 5'd0 : shift_bits;
    sc = (win != last_region) ? 3'd0 : shift_count;
    load_value = sb | 5'((5'(in_data.wdata[0])) << sc);
    load       = 1'b0;
    kk         = 3'd0;

    if (bus_write) begin
      last_region_next = win;
      if (in_data.wdata[7]) begin
        shift_bits_next         = 5'd0;
        shift_count_next        = 3'd0;
        bank_regs_next[REG_CTRL] = bank_regs[REG_CTRL] | CTRL_FORCE_SET;
        prg_window_bank_next[2] = last_bank;
        prg_window_bank_next[3] = last_bank;
      end else if (sc == SHIFT_LAST) begin
        shift_bits_next     = 5'd0;
        shift_count_next    = 3'd0;
        bank_regs_next[win] = load_value;
        load                = 1'b1;
      end else begin
        shift_bits_next  = load_value;
        shift_count_next = sc + 3'd1;
      end
    end

    // The window remap sees the control register as it is after this load.
    ctl    = bank_regs_next[REG_CTRL];
    b8     = CHR_MOD[load_value[4:1]];
    prg_lo = {load_value[3:1], 1'b0};

    if (load && (win == REG_CHR0 || win == REG_CHR1)) begin
      for (int k = 0; k < 8; k++) begin
        kk = 3'(k);
        if (chr_bank_count != 5'd0) begin
          if (ctl[4]) begin
            if (kk[2] == (win == REG_CHR1)) begin
              chr_window_offset_next[k] = {b8, load_value[0], kk[1:0], 10'd0};
            end
          end else if (win == REG_CHR0) begin
            chr_window_offset_next[k] = {b8, kk, 10'd0};
          end
        end else if (ctl[4] && (kk[2] == (win == REG_CHR1))) begin
          // Character RAM is addressed in plain 4KB units.
          chr_window_offset_next[k] = {1'b0, load_value[4:1], kk[1:0], 10'd0};
        end
      end
    end else if (load && win == REG_PRG) begin
      if (ctl[3]) begin
        if (ctl[2]) begin
          prg_window_bank_next[0] = PRG_MOD[load_value[3:0]];
          prg_window_bank_next[1] = PRG_MOD[load_value[3:0]];
        end else begin
          prg_window_bank_next[2] = PRG_MOD[load_value[3:0]];
          prg_window_bank_next[3] = PRG_MOD[load_value[3:0]];
        end
      end else begin
        prg_window_bank_next[0] = PRG_MOD[prg_lo];
        prg_window_bank_next[1] = PRG_MOD[prg_lo];
        prg_window_bank_next[2] = PRG_MOD[prg_lo | 4'd1];
        prg_window_bank_next[3] = PRG_MOD[prg_lo | 4'd1];
      end
    end
  end

  always_comb begin
    rsp.read_value  = 5'd0;
    rsp.phys_offset = 18'd0;
    rsp.mirroring   = bank_regs_next[REG_CTRL][1:0];
    unique case (in_data.cmd)
      CMD_WRITE: begin
      end
      CMD_READ: begin
        rsp.read_value = bank_regs[win];
      end
      CMD_XLT_PRG: begin
        rsp.phys_offset = {prg_window_bank[win], win[0], in_data.addr[12:0]};
      end
      CMD_XLT_CHR: begin
        rsp.phys_offset = {1'b0, chr_window_offset[in_data.addr[12:10]]}
                          + {8'd0, in_data.addr[9:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_BANK_COUNT_RST;
      chr_bank_count <= CHR_BANK_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRG_BANKS: prg_bank_count <= cfg_wdata;
        CFG_CHR_BANKS: chr_bank_count <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits         <= 5'd0;
      shift_count        <= 3'd0;
      last_region        <= 2'd0;
      bank_regs          <= {5'd0, 5'd0, 5'd0, CTRL_RST};
      prg_window_bank    <= {LAST_BANK_RST, LAST_BANK_RST, 4'd0, 4'd0};
      for (int k = 0; k < 8; k++) begin
        chr_window_offset[k] <= {4'd0, 3'(k), 10'd0};
      end
    end else begin
      shift_bits        <= shift_bits_next;
      shift_count       <= shift_count_next;
      last_region       <= last_region_next;
      bank_regs         <= bank_regs_next;
      prg_window_bank   <= prg_window_bank_next;
      chr_window_offset <= chr_window_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= rsp;
    end
  end

`ifndef SYNTHESIS
  // An accepted request always leaves a response behind it.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("response missing after accepted request");

  // The serial loader commits on the fifth bit, so the count never reaches five.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    shift_count <= SHIFT_LAST)
    else $error("shift count out of range");

  // Only bus writes may change the mapper registers.
  a_regs_hold: assert property (@(posedge clk) disable iff (rst)
    !bus_write |=> $stable(bank_regs))
    else $error("mapper registers changed without a write");

  // A reset write forces 16KB program mode with the fixed bank at the top.
  a_reset_write: assert property (@(posedge clk) disable iff (rst)
    bus_write && in_data.wdata[7] |=> bank_regs[REG_CTRL][3:2] == 2'b11)
    else $error("reset write did not force control bits");
`endif

endmodule
